@@ rtl/core/vot_pkg.sv @@
`default_nettype none

package vot_pkg;

   localparam int VOT_OFS_W = 24;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_POS2OFF = 2'd1,
      FUNC_OFF2POS = 2'd2,
      FUNC_CLEAR   = 2'd3
   } vot_func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } vot_status_type;

   typedef struct packed {
      vot_func_type         func;
      logic [7:0]           verse_count;
      logic                 new_book;
      logic                 new_testament;
      logic [7:0]           book_number;
      logic [7:0]           chapter_number;
      logic [7:0]           verse_number;
      logic [VOT_OFS_W-1:0] linear_offset;
   } vot_req_type;

   typedef struct packed {
      logic [7:0]           out_book;
      logic [7:0]           out_chapter;
      logic [7:0]           out_verse;
      logic [VOT_OFS_W-1:0] out_offset;
      vot_status_type       status;
   } vot_rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/vot_if.sv @@
`default_nettype none

interface vot_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  verse_count;
   logic        new_book;
   logic        new_testament;
   logic [7:0]  book_number;
   logic [7:0]  chapter_number;
   logic [7:0]  verse_number;
   logic [23:0] linear_offset;

   modport source (
      output valid, func, verse_count, new_book, new_testament,
             book_number, chapter_number, verse_number, linear_offset,
      input  ready
   );
   modport sink (
      input  valid, func, verse_count, new_book, new_testament,
             book_number, chapter_number, verse_number, linear_offset,
      output ready
   );
endinterface

interface vot_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_book;
   logic [7:0]  out_chapter;
   logic [7:0]  out_verse;
   logic [23:0] out_offset;
   logic [1:0]  status;

   modport source (
      output valid, out_book, out_chapter, out_verse, out_offset, status,
      input  ready
   );
   modport sink (
      input  valid, out_book, out_chapter, out_verse, out_offset, status,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/vot_ram.sv @@
`default_nettype none

module vot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/vot_engine.sv @@
`default_nettype none

module vot_engine #(
   parameter int MAX_BOOKS    = 128,
   parameter int MAX_CHAPTERS = 2048,
   parameter int OFFSET_BITS  = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire vot_pkg::vot_req_type req,
   output logic                     idle,
   output logic                     res_valid,
   input  wire logic                res_take,
   output vot_pkg::vot_rsp_type     res
);

   import vot_pkg::*;

   localparam int BK_IDX = $clog2(MAX_BOOKS);
   localparam int CH_IDX = $clog2(MAX_CHAPTERS);
   localparam int BK_CNT = $clog2(MAX_BOOKS + 1);
   localparam int CH_CNT = $clog2(MAX_CHAPTERS + 1);
   localparam int SW     = (BK_IDX > CH_IDX) ? BK_IDX : CH_IDX;
   localparam int OW     = OFFSET_BITS;
   localparam int CW     = (OFFSET_BITS > VOT_OFS_W) ? OFFSET_BITS : VOT_OFS_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REV_BASE,
      ST_BK_MID,
      ST_BK_IDX,
      ST_BK_CMP,
      ST_RNG_FIRST,
      ST_RNG_END,
      ST_RNG_CHECK,
      ST_CH_MID,
      ST_CH_CMP,
      ST_VM_START,
      ST_VM_NEXT,
      ST_VERDICT,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   vot_req_type       q_ff, q_in;
   vot_rsp_type       res_ff, res_in;
   logic [BK_CNT-1:0] books_ff, books_in;
   logic [CH_CNT-1:0] chapters_ff, chapters_in;
   logic [OW-1:0]     running_ff, running_in;
   logic [OW-1:0]     second_ff, second_in;
   logic              in_second_ff, in_second_in;
   logic [BK_IDX-1:0] b_ff, b_in;
   logic [CH_IDX-1:0] first_ff, first_in;
   logic [CH_CNT-1:0] end_ff, end_in;
   logic [CH_IDX-1:0] c_ff, c_in;
   logic [SW-1:0]     lo_ff, lo_in;
   logic [SW-1:0]     hi_ff, hi_in;
   logic [SW-1:0]     mid_ff, mid_in;
   logic [OW-1:0]     s_ff, s_in;
   logic [OW-1:0]     vmax_ff, vmax_in;

   logic              cs_we;
   logic [CH_IDX-1:0] cs_waddr, cs_raddr;
   logic [OW-1:0]     cs_wdata, cs_rdata;
   logic              bfc_we;
   logic [BK_IDX-1:0] bfc_waddr, bfc_raddr;
   logic [CH_IDX-1:0] bfc_wdata, bfc_rdata;

   logic              tflag, bflag, load_full, trail_sec;
   logic [OW:0]       load_head, load_next;
   logic [SW:0]       mid_sum;
   logic [SW-1:0]     mid_w;
   logic [CW-1:0]     qo_ext, rev_v;
   logic [OW-1:0]     lim;

   vot_ram #(.WIDTH(OW), .DEPTH(MAX_CHAPTERS)) u_chapter_start (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_waddr),
      .wr_data (cs_wdata),
      .rd_addr (cs_raddr),
      .rd_data (cs_rdata)
   );

   vot_ram #(.WIDTH(CH_IDX), .DEPTH(MAX_BOOKS)) u_book_first (
      .clock   (clock),
      .wr_en   (bfc_we),
      .wr_addr (bfc_waddr),
      .wr_data (bfc_wdata),
      .rd_addr (bfc_raddr),
      .rd_data (bfc_rdata)
   );

   assign tflag     = req.new_testament && !in_second_ff;
   assign bflag     = req.new_book || (books_ff == '0);
   assign load_head = (OW+1)'(running_ff) + (OW+1)'(tflag) + (OW+1)'(bflag) + (OW+1)'(1);
   assign load_next = load_head + (OW+1)'(req.verse_count);
   assign load_full = (32'(chapters_ff) >= 32'(MAX_CHAPTERS))
                      || (bflag && (32'(books_ff) >= 32'(MAX_BOOKS)))
                      || load_next[OW];

   assign mid_sum = (SW+1)'(lo_ff) + (SW+1)'(hi_ff) + (SW+1)'(1);
   assign mid_w   = mid_sum[SW:1];
   assign qo_ext  = CW'(q_ff.linear_offset);
   assign rev_v   = qo_ext - CW'(s_ff);

   assign trail_sec = in_second_ff && (second_ff >= s_ff) && (second_ff < cs_rdata);
   assign lim = cs_rdata - OW'(1) - OW'(32'(c_ff) + 32'd1 == 32'(end_ff)) - OW'(trail_sec);

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      res_in       = res_ff;
      books_in     = books_ff;
      chapters_in  = chapters_ff;
      running_in   = running_ff;
      second_in    = second_ff;
      in_second_in = in_second_ff;
      b_in         = b_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      c_in         = c_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      s_in         = s_ff;
      vmax_in      = vmax_ff;
      cs_we        = 1'b0;
      cs_waddr     = chapters_ff[CH_IDX-1:0];
      cs_wdata     = load_head[OW-1:0];
      cs_raddr     = '0;
      bfc_we       = 1'b0;
      bfc_waddr    = books_ff[BK_IDX-1:0];
      bfc_wdata    = chapters_ff[CH_IDX-1:0];
      bfc_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               q_in     = req;
               res_in   = '0;
               state_in = ST_FINISH;
               case (req.func)
                  FUNC_CLEAR: begin
                     books_in          = '0;
                     chapters_in       = '0;
                     running_in        = OW'(1);
                     second_in         = '0;
                     in_second_in      = 1'b0;
                     res_in.out_offset = VOT_OFS_W'(1);
                  end
                  FUNC_LOAD: begin
                     if (load_full) begin
                        res_in.out_offset = VOT_OFS_W'(running_ff);
                        res_in.status     = STAT_FULL;
                     end else begin
                        if (tflag) begin
                           second_in    = running_ff;
                           in_second_in = 1'b1;
                        end
                        if (bflag) begin
                           bfc_we   = 1'b1;
                           books_in = books_ff + BK_CNT'(1);
                        end
                        cs_we             = 1'b1;
                        chapters_in       = chapters_ff + CH_CNT'(1);
                        running_in        = load_next[OW-1:0];
                        res_in.out_offset = VOT_OFS_W'(load_next[OW-1:0]);
                     end
                  end
                  FUNC_POS2OFF: begin
                     if ((req.book_number == '0)
                         || (32'(req.book_number) > 32'(books_ff))) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        b_in      = BK_IDX'(32'(req.book_number) - 32'd1);
                        bfc_raddr = b_in;
                        state_in  = ST_RNG_FIRST;
                     end
                  end
                  FUNC_OFF2POS: begin
                     if (books_ff == '0) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        cs_raddr = '0;
                        state_in = ST_REV_BASE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REV_BASE: begin
            if (qo_ext < CW'(cs_rdata)) begin
               res_in.status = STAT_RANGE;
               state_in      = ST_FINISH;
            end else begin
               lo_in    = '0;
               hi_in    = SW'(32'(books_ff) - 32'd1);
               state_in = ST_BK_MID;
            end
         end
         ST_BK_MID: begin
            if (lo_ff < hi_ff) begin
               mid_in    = mid_w;
               bfc_raddr = mid_w[BK_IDX-1:0];
               state_in  = ST_BK_IDX;
            end else begin
               b_in      = lo_ff[BK_IDX-1:0];
               bfc_raddr = lo_ff[BK_IDX-1:0];
               state_in  = ST_RNG_FIRST;
            end
         end
         ST_BK_IDX: begin
            cs_raddr = bfc_rdata;
            state_in = ST_BK_CMP;
         end
         ST_BK_CMP: begin
            if (CW'(cs_rdata) <= qo_ext) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - SW'(1);
            end
            state_in = ST_BK_MID;
         end
         ST_RNG_FIRST: begin
            first_in = bfc_rdata;
            if (32'(b_ff) + 32'd1 < 32'(books_ff)) begin
               bfc_raddr = BK_IDX'(32'(b_ff) + 32'd1);
               state_in  = ST_RNG_END;
            end else begin
               end_in   = chapters_ff;
               state_in = ST_RNG_CHECK;
            end
         end
         ST_RNG_END: begin
            end_in   = CH_CNT'(bfc_rdata);
            state_in = ST_RNG_CHECK;
         end
         ST_RNG_CHECK: begin
            if (q_ff.func == FUNC_POS2OFF) begin
               if ((q_ff.chapter_number == '0) || (32'(q_ff.chapter_number)
                   > 32'(end_ff) - 32'(first_ff))) begin
                  res_in.status = STAT_RANGE;
                  state_in      = ST_FINISH;
               end else begin
                  c_in     = CH_IDX'(32'(first_ff) + 32'(q_ff.chapter_number) - 32'd1);
                  cs_raddr = c_in;
                  state_in = ST_VM_START;
               end
            end else begin
               lo_in    = SW'(first_ff);
               hi_in    = SW'(32'(end_ff) - 32'd1);
               state_in = ST_CH_MID;
            end
         end
         ST_CH_MID: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_w;
               cs_raddr = mid_w[CH_IDX-1:0];
               state_in = ST_CH_CMP;
            end else begin
               c_in     = lo_ff[CH_IDX-1:0];
               cs_raddr = lo_ff[CH_IDX-1:0];
               state_in = ST_VM_START;
            end
         end
         ST_CH_CMP: begin
            if (CW'(cs_rdata) <= qo_ext) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - SW'(1);
            end
            state_in = ST_CH_MID;
         end
         ST_VM_START: begin
            s_in = cs_rdata;
            if (32'(c_ff) + 32'd1 >= 32'(chapters_ff)) begin
               vmax_in  = running_ff - cs_rdata;
               state_in = ST_VERDICT;
            end else begin
               cs_raddr = CH_IDX'(32'(c_ff) + 32'd1);
               state_in = ST_VM_NEXT;
            end
         end
         ST_VM_NEXT: begin
            vmax_in  = lim - s_ff;
            state_in = ST_VERDICT;
         end
         ST_VERDICT: begin
            state_in = ST_FINISH;
            if (q_ff.func == FUNC_POS2OFF) begin
               if (CW'(q_ff.verse_number) > CW'(vmax_ff)) begin
                  res_in.status = STAT_RANGE;
               end else begin
                  res_in.out_offset = VOT_OFS_W'(CW'(s_ff) + CW'(q_ff.verse_number));
               end
            end else begin
               if (rev_v > CW'(vmax_ff)) begin
                  res_in.status = STAT_RANGE;
               end else begin
                  res_in.out_book    = 8'(32'(b_ff) + 32'd1);
                  res_in.out_chapter = 8'(32'(c_ff) - 32'(first_ff) + 32'd1);
                  res_in.out_verse   = rev_v[7:0];
               end
            end
         end
         ST_FINISH: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         books_ff     <= '0;
         chapters_ff  <= '0;
         running_ff   <= OW'(1);
         second_ff    <= '0;
         in_second_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         books_ff     <= books_in;
         chapters_ff  <= chapters_in;
         running_ff   <= running_in;
         second_ff    <= second_in;
         in_second_ff <= in_second_in;
      end
      q_ff    <= q_in;
      res_ff  <= res_in;
      b_ff    <= b_in;
      first_ff <= first_in;
      end_ff  <= end_in;
      c_ff    <= c_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      s_ff    <= s_in;
      vmax_ff <= vmax_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FINISH);
   assign res       = res_ff;

endmodule

`default_nettype wire

@@ rtl/core/verse_offset_translator.sv @@
// Verse offset translator.
// Request beats arrive on req_if: func selects a chapter load, a position to
// offset query, an offset to position query or a table clear. Every request
// beat yields exactly one response beat on rsp_if, in request order.
// One request is worked on at a time; req_if.ready is high while the engine
// is idle. Load and clear go from idle straight to the finished state, and the
// response passes through the engine result register and then the output
// register. A forward query chains reads of the book table and the chapter
// table. A reverse query binary searches the books and then the chapters of
// the book: each book probe reads the book table and then the chapter table,
// each chapter probe one chapter table read.
// A finished response sits in an output register, so the next request is
// taken while the receiver stalls; a second response then waits in the
// engine, which holds off further requests until the register drains.
// Reset, like a clear request, empties the table and sets the running offset
// to 1. The table memories are not swept; entries beyond the loaded counts
// are never read.
`default_nettype none

module verse_offset_translator #(
   parameter int MAX_BOOKS    = 128,
   parameter int MAX_CHAPTERS = 2048,
   parameter int OFFSET_BITS  = 24
) (
   input wire logic clock,
   input wire logic reset,
   vot_req_if.sink  req_if,
   vot_rsp_if.source rsp_if
);

   import vot_pkg::*;

   vot_req_type req_pl;
   vot_rsp_type eng_res;
   vot_rsp_type rsp_ff;
   logic        rsp_valid_ff;
   logic        eng_idle, eng_res_valid, eng_take, req_fire;

   assign req_pl.func           = vot_func_type'(req_if.func);
   assign req_pl.verse_count    = req_if.verse_count;
   assign req_pl.new_book       = req_if.new_book;
   assign req_pl.new_testament  = req_if.new_testament;
   assign req_pl.book_number    = req_if.book_number;
   assign req_pl.chapter_number = req_if.chapter_number;
   assign req_pl.verse_number   = req_if.verse_number;
   assign req_pl.linear_offset  = req_if.linear_offset;

   assign req_if.ready = eng_idle;
   assign req_fire     = req_if.valid && eng_idle;
   assign eng_take     = eng_res_valid && (!rsp_valid_ff || rsp_if.ready);

   vot_engine #(
      .MAX_BOOKS    (MAX_BOOKS),
      .MAX_CHAPTERS (MAX_CHAPTERS),
      .OFFSET_BITS  (OFFSET_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .req       (req_pl),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res_take  (eng_take),
      .res       (eng_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (eng_take) begin
         rsp_ff <= eng_res;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_book    = rsp_ff.out_book;
   assign rsp_if.out_chapter = rsp_ff.out_chapter;
   assign rsp_if.out_verse   = rsp_ff.out_verse;
   assign rsp_if.out_offset  = rsp_ff.out_offset;
   assign rsp_if.status      = rsp_ff.status;

   a_ready_not_finished: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !eng_res_valid)
      else $error("request ready while a response is pending in the engine");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("engine still ready after taking a request beat");

   a_take_fills_output: assert property (@(posedge clock) disable iff (reset)
      eng_take |=> rsp_if.valid)
      else $error("response taken from engine but output register empty");

endmodule

`default_nettype wire

@@ verif/tb_verse_offset_translator.sv @@
import vot_pkg::*;

class verse_map_checker;
   localparam int BOOK_CAP = 128;
   localparam int CHAPTER_CAP = 2048;
   localparam longint OFFSET_MAX = 64'hFF_FFFF;

   int chap_start [CHAPTER_CAP];
   int book_first [BOOK_CAP];
   int books_loaded;
   int chapters_loaded;
   int running_offset;
   int second_start;
   bit in_second;
   vot_rsp_type pending_answers [$];
   int errors;

   function new();
      clear_table();
      errors = 0;
   endfunction

   function void clear_table();
      books_loaded = 0;
      chapters_loaded = 0;
      running_offset = 1;
      second_start = 0;
      in_second = 0;
   endfunction

   function int book_stop(int b);
      if (b + 1 < books_loaded) return book_first[b + 1];
      return chapters_loaded;
   endfunction

   function int verse_limit(int c, bit next_opens_book);
      int lim;
      if (c + 1 >= chapters_loaded) return running_offset - chap_start[c];
      lim = chap_start[c + 1] - 1;
      if (next_opens_book) lim--;
      if (in_second && second_start >= chap_start[c] && second_start < chap_start[c + 1]) lim--;
      return lim - chap_start[c];
   endfunction

   function vot_rsp_type translate(vot_req_type r);
      vot_rsp_type a;
      bit tflag;
      bit bflag;
      longint next_ofs;
      int b, first, stop, c, v, lo, hi, mid;
      a = '0;
      case (r.func)
         FUNC_CLEAR: begin
            clear_table();
            a.out_offset = 24'(running_offset);
         end
         FUNC_LOAD: begin
            tflag = r.new_testament && !in_second;
            bflag = r.new_book || books_loaded == 0;
            next_ofs = longint'(running_offset) + tflag + bflag + 1 + r.verse_count;
            if (chapters_loaded >= CHAPTER_CAP || (bflag && books_loaded >= BOOK_CAP)
                || next_ofs > OFFSET_MAX) begin
               a.out_offset = 24'(running_offset);
               a.status = STAT_FULL;
            end else begin
               if (tflag) begin
                  second_start = running_offset;
                  running_offset++;
                  in_second = 1;
               end
               if (bflag) begin
                  running_offset++;
                  book_first[books_loaded] = chapters_loaded;
                  books_loaded++;
               end
               running_offset++;
               chap_start[chapters_loaded] = running_offset;
               chapters_loaded++;
               running_offset += r.verse_count;
               a.out_offset = 24'(running_offset);
            end
         end
         FUNC_POS2OFF: begin
            if (r.book_number == 0 || r.book_number > books_loaded) begin
               a.status = STAT_RANGE;
            end else begin
               b = r.book_number - 1;
               first = book_first[b];
               stop = book_stop(b);
               c = first + r.chapter_number - 1;
               if (r.chapter_number == 0 || r.chapter_number > stop - first)
                  a.status = STAT_RANGE;
               else if (r.verse_number > verse_limit(c, c + 1 == stop))
                  a.status = STAT_RANGE;
               else
                  a.out_offset = 24'(chap_start[c] + r.verse_number);
            end
         end
         FUNC_OFF2POS: begin
            if (books_loaded == 0 || r.linear_offset < chap_start[0]) begin
               a.status = STAT_RANGE;
            end else begin
               lo = 0;
               hi = books_loaded - 1;
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (chap_start[book_first[mid]] <= r.linear_offset) lo = mid;
                  else hi = mid - 1;
               end
               b = lo;
               first = book_first[b];
               stop = book_stop(b);
               lo = first;
               hi = stop - 1;
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (chap_start[mid] <= r.linear_offset) lo = mid;
                  else hi = mid - 1;
               end
               c = lo;
               v = r.linear_offset - chap_start[c];
               if (v > verse_limit(c, c + 1 == stop)) begin
                  a.status = STAT_RANGE;
               end else begin
                  a.out_book = 8'(b + 1);
                  a.out_chapter = 8'(c - first + 1);
                  a.out_verse = 8'(v);
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function void note_request(vot_req_type r);
      pending_answers = {pending_answers, translate(r)};
   endfunction

   function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function void check_answer(vot_rsp_type got);
      vot_rsp_type want;
      if (pending_answers.size() == 0) begin
         $error("response beat with no request outstanding");
         errors++;
         return;
      end
      want = pending_answers.pop_front();
      compare_field("out_book", want.out_book, got.out_book);
      compare_field("out_chapter", want.out_chapter, got.out_chapter);
      compare_field("out_verse", want.out_verse, got.out_verse);
      compare_field("out_offset", want.out_offset, got.out_offset);
      compare_field("status", want.status, got.status);
   endfunction
endclass

module tb_verse_offset_translator;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 250;
   localparam int FILL_BOOKS = 130;

   logic clock;
   logic reset;
   int quiet_cycles;
   int ready_run;
   bit ready_level;
   int burst_left;
   verse_map_checker ledger;

   vot_req_if req_bus ();
   vot_rsp_if rsp_bus ();

   verse_offset_translator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin : receiver
      vot_rsp_type seen;
      if (rsp_bus.valid && rsp_bus.ready) begin
         seen.out_book = rsp_bus.out_book;
         seen.out_chapter = rsp_bus.out_chapter;
         seen.out_verse = rsp_bus.out_verse;
         seen.out_offset = rsp_bus.out_offset;
         seen.status = vot_status_type'(rsp_bus.status);
         ledger.check_answer(seen);
      end
      if (ready_run == 0) begin
         ready_level = ($urandom_range(0, 99) < 65);
         ready_run = ready_level ? $urandom_range(1, 30) : $urandom_range(1, 15);
      end
      ready_run--;
      rsp_bus.ready <= ready_level;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic vot_req_type noise_request();
      vot_req_type r;
      r.func = vot_func_type'($urandom_range(0, 3));
      r.verse_count = 8'($urandom_range(0, 255));
      r.new_book = 1'($urandom_range(0, 1));
      r.new_testament = 1'($urandom_range(0, 1));
      r.book_number = 8'($urandom_range(0, 255));
      r.chapter_number = 8'($urandom_range(0, 255));
      r.verse_number = 8'($urandom_range(0, 255));
      r.linear_offset = 24'($urandom);
      return r;
   endfunction

   function automatic vot_req_type load_request(int count, bit nb, bit nt);
      vot_req_type r;
      r = noise_request();
      r.func = FUNC_LOAD;
      r.verse_count = 8'(count);
      r.new_book = nb;
      r.new_testament = nt;
      return r;
   endfunction

   function automatic vot_req_type clear_request();
      vot_req_type r;
      r = noise_request();
      r.func = FUNC_CLEAR;
      return r;
   endfunction

   function automatic vot_req_type position_query(int b, int c, int v);
      vot_req_type r;
      r = noise_request();
      r.func = FUNC_POS2OFF;
      r.book_number = 8'(b);
      r.chapter_number = 8'(c);
      r.verse_number = 8'(v);
      return r;
   endfunction

   function automatic vot_req_type offset_query(int o);
      vot_req_type r;
      r = noise_request();
      r.func = FUNC_OFF2POS;
      r.linear_offset = 24'(o);
      return r;
   endfunction

   function automatic int pick_count();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 255;
         2: return $urandom_range(0, 255);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic vot_req_type forward_request(bit well_formed);
      vot_req_type r;
      int b, first, nchap, c, vmax;
      r = position_query($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
      if (ledger.books_loaded == 0) return r;
      b = $urandom_range(1, ledger.books_loaded);
      first = ledger.book_first[b - 1];
      nchap = ledger.book_stop(b - 1) - first;
      c = $urandom_range(1, nchap);
      vmax = ledger.verse_limit(first + c - 1, first + c == ledger.book_stop(b - 1));
      r.book_number = 8'(b);
      r.chapter_number = 8'(c);
      r.verse_number = 8'($urandom_range(0, vmax));
      if (!well_formed) begin
         case ($urandom_range(0, 5))
            0: r.book_number = '0;
            1: r.book_number = 8'(ledger.books_loaded + 1);
            2: r.chapter_number = '0;
            3: r.chapter_number = 8'(nchap + 1);
            4: r.verse_number = 8'(vmax + 1);
            default: r.book_number = 8'($urandom_range(0, 255));
         endcase
      end
      return r;
   endfunction

   function automatic vot_req_type reverse_request(bit well_formed);
      vot_req_type r;
      r = offset_query($urandom);
      if (well_formed && ledger.books_loaded > 0)
         r.linear_offset = 24'($urandom_range(ledger.chap_start[0] - 3,
                                              ledger.running_offset + 2));
      else if ($urandom_range(0, 1))
         r.linear_offset = 24'($urandom_range(0, 4));
      return r;
   endfunction

   function automatic vot_req_type random_request();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30)
         return load_request(pick_count(), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 11) == 0);
      if (sel < 60) return forward_request($urandom_range(0, 4) != 0);
      if (sel < 92) return reverse_request($urandom_range(0, 4) != 0);
      if (sel < 94) return clear_request();
      return noise_request();
   endfunction

   task automatic send_request(input vot_req_type r);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.func <= r.func;
      req_bus.verse_count <= r.verse_count;
      req_bus.new_book <= r.new_book;
      req_bus.new_testament <= r.new_testament;
      req_bus.book_number <= r.book_number;
      req_bus.chapter_number <= r.chapter_number;
      req_bus.verse_number <= r.verse_number;
      req_bus.linear_offset <= r.linear_offset;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      ledger.note_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (ledger.pending_answers.size() != 0) @(posedge clock);
   endtask

   initial begin
      ledger = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_LOAD;
      req_bus.verse_count = '0;
      req_bus.new_book = 1'b0;
      req_bus.new_testament = 1'b0;
      req_bus.book_number = '0;
      req_bus.chapter_number = '0;
      req_bus.verse_number = '0;
      req_bus.linear_offset = '0;
      rsp_bus.ready = 1'b0;
      quiet_cycles = 0;
      ready_run = 0;
      burst_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(position_query(1, 1, 0));
      send_request(offset_query(0));
      // The first chapter opens a book even without the new book flag.
      send_request(load_request(0, 0, 0));
      send_request(load_request(255, 0, 0));
      send_request(load_request(3, 1, 0));
      send_request(load_request(5, 1, 1));
      // A second testament flag after the first one is ignored.
      send_request(load_request(2, 0, 1));
      send_request(load_request(0, 1, 1));
      send_request(position_query(0, 1, 0));
      send_request(position_query(255, 1, 0));
      send_request(position_query(1, 0, 0));
      send_request(position_query(1, 2, 255));
      send_request(position_query(1, 3, 0));
      send_request(position_query(2, 1, 4));
      send_request(position_query(4, 1, 0));
      send_request(offset_query(2));
      send_request(offset_query(3));
      send_request(offset_query(ledger.second_start));
      send_request(offset_query(ledger.chap_start[2] - 1));
      send_request(offset_query(ledger.running_offset));
      send_request(offset_query(ledger.running_offset + 1));
      send_request(offset_query(24'hFF_FFFF));
      send_request(clear_request());
      send_request(position_query(1, 1, 0));
      send_request(offset_query(3));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain_all();
         send_request(random_request());
      end

      // Fill the book table past its limit, then query it.
      send_request(clear_request());
      repeat (FILL_BOOKS)
         send_request(load_request(pick_count(), 1'b1, $urandom_range(0, 99) == 0));
      repeat (4) send_request(load_request(pick_count(), $urandom_range(0, 1) == 1, 1'b0));
      repeat (40) begin
         if ($urandom_range(0, 1))
            send_request(forward_request($urandom_range(0, 3) != 0));
         else
            send_request(reverse_request($urandom_range(0, 3) != 0));
      end
      send_request(clear_request());

      drain_all();
      repeat (20) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending_answers.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
